// ===== sv/spq_pkg.sv =====
// Package for the stable priority queue: widths, command and status codes,
// the internal operation type and the structs passed from the top level to each cell.
// No dependencies.
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int NAME_W    = 32;
  localparam int PRIO_W    = 8;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 4;
  localparam int STAT_W    = 2;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ENQ,
    OP_PUSH_HEAD,
    OP_PUSH_TAIL,
    OP_POP_HEAD,
    OP_POP_TAIL,
    OP_FIND,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NAME_W-1:0] name;
    logic [PRIO_W-1:0] prio;
  } cell_ctrl_t;

  typedef struct packed {
    logic occupied;   // slot index below the entry count
    logic tail_slot;  // slot index equal to the entry count
    logic last;       // slot holds the tail entry
    logic head;       // slot zero
    logic pos_eq;     // slot index equals the requested read position
  } cell_flags_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the queue chain: holds one entry, shifts with its neighbors,
// and takes part in the priority and name searches. Depends on spq_pkg.
module spq_cell (
  input  logic                       clk,
  input  logic                       en,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  spq_pkg::cell_flags_t       flags,
  input  logic [spq_pkg::NAME_W-1:0] left_name,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [spq_pkg::NAME_W-1:0] right_name,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  input  logic                       carry_in,
  output logic                       carry_out,
  output logic                       sel,
  output logic [spq_pkg::NAME_W-1:0] name,
  output logic [spq_pkg::PRIO_W-1:0] prio
);

  logic [spq_pkg::NAME_W-1:0] name_next;
  logic [spq_pkg::PRIO_W-1:0] prio_next;
  logic hit;
  logic match;
  logic trigger;

  // The new entry goes before the first occupied slot of strictly lower priority,
  // or into the first free slot if no such entry exists.
  assign hit   = flags.occupied && ($signed(prio) < $signed(ctrl.prio));
  assign match = flags.occupied && (name == ctrl.name);

  always_comb begin
    case (ctrl.op)
      spq_pkg::OP_ENQ:  trigger = hit || !flags.occupied;
      spq_pkg::OP_FIND: trigger = match;
      default:          trigger = 1'b0;
    endcase
  end

  assign carry_out = carry_in | trigger;

  always_comb begin
    case (ctrl.op)
      spq_pkg::OP_POP_HEAD: sel = flags.head && flags.occupied;
      spq_pkg::OP_POP_TAIL: sel = flags.last;
      spq_pkg::OP_FIND:     sel = match && !carry_in;
      spq_pkg::OP_READ:     sel = flags.pos_eq && flags.occupied;
      default:              sel = 1'b0;
    endcase
  end

  always_comb begin
    name_next = name;
    prio_next = prio;
    case (ctrl.op)
      spq_pkg::OP_ENQ: begin
        if (carry_in) begin
          name_next = left_name;
          prio_next = left_prio;
        end else if (trigger) begin
          name_next = ctrl.name;
          prio_next = ctrl.prio;
        end
      end
      spq_pkg::OP_PUSH_HEAD: begin
        name_next = left_name;
        prio_next = left_prio;
      end
      spq_pkg::OP_PUSH_TAIL: begin
        if (flags.tail_slot) begin
          name_next = ctrl.name;
          prio_next = ctrl.prio;
        end
      end
      spq_pkg::OP_POP_HEAD: begin
        name_next = right_name;
        prio_next = right_prio;
      end
      default: begin
        name_next = name;
        prio_next = prio;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      name <= name_next;
      prio <= prio_next;
    end
  end

endmodule

// ===== sv/stable_priority_queue_unit.sv =====
// Top level of the stable priority queue: command decode, entry count, the chain
// of slot cells and the registered result stage. Depends on spq_pkg and spq_cell.
//
// Usage: one command is a transfer on the input channel (in_valid / in_stall with
// command, item_name, item_priority, position). Every command produces exactly one
// result transfer on the output channel (out_valid / out_stall with status, out_name,
// out_priority, out_position, entry_count).
// The entries live in a chain of DEPTH identical cells, slot zero being the head.
// On each accepted command every cell decides locally whether to hold, shift from
// its left or right neighbor, or load the new entry; a carry runs along the chain
// to mark the first lower-priority or free slot (enqueue) or first name match (find).
// The result appears on the output register in the cycle after the command is
// accepted. One command is taken per cycle while the receiver does not stall; the
// output register lets a new command be taken in the same cycle that the previous
// result is transferred.
// When the receiver stalls and a result is waiting, in_stall rises and the queue
// holds its state until the result is taken.
// Reset clears the entry count and the output valid flag. Slot contents are not
// cleared; slots at or beyond the entry count are never reported.
// A push into a full queue is dropped with status full; a pop from an empty queue,
// a failed find, an out-of-range read or an unused command gives status miss.
module stable_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spq_pkg::CMD_W-1:0]   command,
  input  logic [spq_pkg::NAME_W-1:0]  item_name,
  input  logic signed [spq_pkg::PRIO_W-1:0] item_priority,
  input  logic [spq_pkg::POS_W-1:0]   position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spq_pkg::STAT_W-1:0]  status,
  output logic [spq_pkg::NAME_W-1:0]  out_name,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::POS_W-1:0]   out_position,
  output logic [4:0]                  entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  logic          lookup;
  logic [spq_pkg::STAT_W-1:0] stat_pre;
  spq_pkg::cell_ctrl_t ctrl;

  logic [spq_pkg::NAME_W-1:0] cell_name [DEPTH];
  logic [spq_pkg::PRIO_W-1:0] cell_prio [DEPTH];
  logic [DEPTH-1:0]           cell_sel;
  logic [DEPTH:0]             carry;

  logic [spq_pkg::NAME_W-1:0] pick_name;
  logic [spq_pkg::PRIO_W-1:0] pick_prio;
  logic [IW-1:0]              pick_idx;
  logic                       pick_any;

  // The output register is free, or its result is taken in this cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Command decode; a command that cannot take effect becomes a no-op for the chain.
  always_comb begin
    ctrl.name  = item_name;
    ctrl.prio  = item_priority;
    ctrl.op    = spq_pkg::OP_NOP;
    stat_pre   = spq_pkg::ST_OK;
    lookup     = 1'b0;
    count_next = count;
    case (command)
      spq_pkg::CMD_ENQUEUE, spq_pkg::CMD_PUSH_HEAD, spq_pkg::CMD_PUSH_TAIL: begin
        if (full) begin
          stat_pre = spq_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
          if (command == spq_pkg::CMD_ENQUEUE) begin
            ctrl.op = spq_pkg::OP_ENQ;
          end else if (command == spq_pkg::CMD_PUSH_HEAD) begin
            ctrl.op = spq_pkg::OP_PUSH_HEAD;
          end else begin
            ctrl.op = spq_pkg::OP_PUSH_TAIL;
          end
        end
      end
      spq_pkg::CMD_POP_HEAD, spq_pkg::CMD_POP_TAIL: begin
        if (empty) begin
          stat_pre = spq_pkg::ST_MISS;
        end else begin
          count_next = count - CW'(1);
          ctrl.op = (command == spq_pkg::CMD_POP_HEAD) ? spq_pkg::OP_POP_HEAD
                                                       : spq_pkg::OP_POP_TAIL;
        end
      end
      spq_pkg::CMD_FIND: begin
        ctrl.op = spq_pkg::OP_FIND;
        lookup  = 1'b1;
      end
      spq_pkg::CMD_READ: begin
        ctrl.op = spq_pkg::OP_READ;
        lookup  = 1'b1;
      end
      default: begin
        stat_pre = spq_pkg::ST_MISS;
      end
    endcase
  end

  assign carry[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::cell_flags_t       flags;
    logic [spq_pkg::NAME_W-1:0] left_name;
    logic [spq_pkg::PRIO_W-1:0] left_prio;
    logic [spq_pkg::NAME_W-1:0] right_name;
    logic [spq_pkg::PRIO_W-1:0] right_prio;

    assign flags.occupied  = CW'(i) < count;
    assign flags.tail_slot = CW'(i) == count;
    assign flags.last      = CW'(i + 1) == count;
    assign flags.head      = (i == 0);

    // Read position reaches only the slots that a position field can address.
    if (i < (1 << spq_pkg::POS_W)) begin : g_pos
      assign flags.pos_eq = (position == spq_pkg::POS_W'(i));
    end else begin : g_nopos
      assign flags.pos_eq = 1'b0;
    end

    if (i == 0) begin : g_head
      assign left_name = item_name;
      assign left_prio = item_priority;
    end else begin : g_mid
      assign left_name = cell_name[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_name = '0;
      assign right_prio = '0;
    end else begin : g_inner
      assign right_name = cell_name[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .en         (accept),
      .ctrl       (ctrl),
      .flags      (flags),
      .left_name  (left_name),
      .left_prio  (left_prio),
      .right_name (right_name),
      .right_prio (right_prio),
      .carry_in   (carry[i]),
      .carry_out  (carry[i+1]),
      .sel        (cell_sel[i]),
      .name       (cell_name[i]),
      .prio       (cell_prio[i])
    );
  end

  // At most one cell selects itself, so the picked entry is an OR of masked slots.
  always_comb begin
    pick_name = '0;
    pick_prio = '0;
    pick_idx  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_sel[i]) begin
        pick_name = pick_name | cell_name[i];
        pick_prio = pick_prio | cell_prio[i];
        pick_idx  = pick_idx | IW'(i);
      end
    end
  end

  assign pick_any = |cell_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= (lookup && !pick_any) ? spq_pkg::ST_MISS : stat_pre;
      out_name     <= pick_name;
      out_priority <= pick_prio;
      out_position <= (ctrl.op == spq_pkg::OP_FIND) ? spq_pkg::POS_W'(pick_idx) : '0;
      entry_count  <= 5'(count_next);
    end
  end

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_unit.
module spq_port_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic [spq_pkg::STAT_W-1:0] status,
  input logic [spq_pkg::NAME_W-1:0] out_name,
  input logic [spq_pkg::PRIO_W-1:0] out_priority,
  input logic [spq_pkg::POS_W-1:0]  out_position,
  input logic [4:0]                 entry_count
);

  localparam logic [4:0] DEPTH_LOW = 5'(DEPTH);

  // Every accepted command yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted command produced no result");

  // A dropped push only happens on a full queue.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_FULL |-> entry_count == DEPTH_LOW)
    else $error("full status with a count below depth");

  // A failed command reports no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != spq_pkg::ST_OK |->
      out_name == '0 && out_priority == '0 && out_position == '0)
    else $error("failed command reported entry data");

  // Nothing is reported out of reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stable_priority_queue_unit spq_port_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .status       (status),
  .out_name     (out_name),
  .out_priority (out_priority),
  .out_position (out_position),
  .entry_count  (entry_count)
);

// ===== tb/spq_checker.sv =====
// Checker for the stable priority queue: watches both channels, keeps its own
// copy of the queue to predict each result, and compares every result transfer.
// Depends on spq_pkg.
module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [spq_pkg::CMD_W-1:0]         command,
  input  logic [spq_pkg::NAME_W-1:0]        item_name,
  input  logic signed [spq_pkg::PRIO_W-1:0] item_priority,
  input  logic [spq_pkg::POS_W-1:0]         position,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [spq_pkg::STAT_W-1:0]        status,
  input  logic [spq_pkg::NAME_W-1:0]        out_name,
  input  logic signed [spq_pkg::PRIO_W-1:0] out_priority,
  input  logic [spq_pkg::POS_W-1:0]         out_position,
  input  logic [4:0]                        entry_count,
  output int                                mismatches,
  output int                                outstanding
);

  typedef struct packed {
    logic [spq_pkg::STAT_W-1:0]        status;
    logic [spq_pkg::NAME_W-1:0]        name;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::POS_W-1:0]         pos;
    logic [4:0]                        count;
  } queue_result_t;

  // Shadow copy of the queue, head at index zero.
  logic [spq_pkg::NAME_W-1:0]        shadow_name [DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] shadow_prio [DEPTH];
  int                                held;

  queue_result_t awaited_results [$];
  int            errors;

  function automatic queue_result_t apply_command(
    input logic [spq_pkg::CMD_W-1:0]         cmd,
    input logic [spq_pkg::NAME_W-1:0]        nm,
    input logic signed [spq_pkg::PRIO_W-1:0] pr,
    input logic [spq_pkg::POS_W-1:0]         ps
  );
    queue_result_t r;
    int at;
    int i;
    r = '0;
    r.status = spq_pkg::ST_OK;
    case (cmd)
      spq_pkg::CMD_ENQUEUE, spq_pkg::CMD_PUSH_HEAD, spq_pkg::CMD_PUSH_TAIL: begin
        if (held >= DEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          at = held;
          if (cmd == spq_pkg::CMD_PUSH_HEAD) begin
            at = 0;
          end else if (cmd == spq_pkg::CMD_ENQUEUE) begin
            // Scanning from the tail leaves the first strictly lower entry from the head.
            for (i = held - 1; i >= 0; i--) begin
              if (pr > shadow_prio[i]) at = i;
            end
          end
          for (i = held; i > at; i--) begin
            shadow_name[i] = shadow_name[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_name[at] = nm;
          shadow_prio[at] = pr;
          held++;
        end
      end
      spq_pkg::CMD_POP_HEAD, spq_pkg::CMD_POP_TAIL: begin
        if (held == 0) begin
          r.status = spq_pkg::ST_MISS;
        end else begin
          at = (cmd == spq_pkg::CMD_POP_HEAD) ? 0 : held - 1;
          r.name = shadow_name[at];
          r.prio = shadow_prio[at];
          for (i = at; i + 1 < held; i++) begin
            shadow_name[i] = shadow_name[i+1];
            shadow_prio[i] = shadow_prio[i+1];
          end
          held--;
        end
      end
      spq_pkg::CMD_FIND: begin
        r.status = spq_pkg::ST_MISS;
        for (i = held - 1; i >= 0; i--) begin
          if (shadow_name[i] == nm) begin
            r.status = spq_pkg::ST_OK;
            r.name = shadow_name[i];
            r.prio = shadow_prio[i];
            r.pos = i[spq_pkg::POS_W-1:0];
          end
        end
      end
      spq_pkg::CMD_READ: begin
        if (int'(ps) < held) begin
          r.name = shadow_name[ps];
          r.prio = shadow_prio[ps];
        end else begin
          r.status = spq_pkg::ST_MISS;
        end
      end
      default: begin
        r.status = spq_pkg::ST_MISS;
      end
    endcase
    r.count = held[4:0];
    return r;
  endfunction

  task automatic check_field(input string label, input logic [spq_pkg::NAME_W-1:0] want,
                             input logic [spq_pkg::NAME_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    queue_result_t want;
    if (rst) begin
      held = 0;
      awaited_results.delete();
    end else begin
      // The result taken now belongs to an earlier command, so compare before predicting.
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d name %h count %0d",
                   $time, status, out_name, entry_count);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", spq_pkg::NAME_W'(want.status), spq_pkg::NAME_W'(status));
          check_field("out_name", want.name, out_name);
          check_field("out_priority", spq_pkg::NAME_W'(want.prio),
                      spq_pkg::NAME_W'(out_priority));
          check_field("out_position", spq_pkg::NAME_W'(want.pos),
                      spq_pkg::NAME_W'(out_position));
          check_field("entry_count", spq_pkg::NAME_W'(want.count),
                      spq_pkg::NAME_W'(entry_count));
        end
      end
      if (in_valid && !in_stall) begin
        awaited_results.push_back(apply_command(command, item_name, item_priority, position));
      end
    end
    mismatches <= errors;
    outstanding <= awaited_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the stable priority queue: clock, reset, command stimulus,
// receiver stalls, watchdog and verdict. Depends on spq_pkg, spq_checker and
// stable_priority_queue_unit.
module tb_top;

  // The command field allows one code that the block does not use.
  localparam logic [spq_pkg::CMD_W-1:0] CMD_SPARE = 3'd7;
  // Cycles without any transfer before the run is declared hung. The slowest
  // correct stretch is the long receiver hold plus a few random gaps.
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 40;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic [spq_pkg::CMD_W-1:0]         command;
  logic [spq_pkg::NAME_W-1:0]        item_name;
  logic signed [spq_pkg::PRIO_W-1:0] item_priority;
  logic [spq_pkg::POS_W-1:0]         position;
  logic                              out_valid;
  logic                              out_stall;
  logic [spq_pkg::STAT_W-1:0]        status;
  logic [spq_pkg::NAME_W-1:0]        out_name;
  logic signed [spq_pkg::PRIO_W-1:0] out_priority;
  logic [spq_pkg::POS_W-1:0]         out_position;
  logic [4:0]                        entry_count;
  int                                mismatches;
  int                                outstanding;

  // Idle rates in percent per cycle, changed by the stimulus between phases.
  int send_idle_pct;
  int recv_stall_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request;

  // A small pool of names makes finds hit and lets duplicate names occur.
  logic [spq_pkg::NAME_W-1:0] name_pool [8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  stable_priority_queue_unit #(.DEPTH(spq_pkg::DEPTH_DEF)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .item_name(item_name),
    .item_priority(item_priority),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .out_name(out_name),
    .out_priority(out_priority),
    .out_position(out_position),
    .entry_count(entry_count)
  );

  spq_checker #(.DEPTH(spq_pkg::DEPTH_DEF)) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .item_name(item_name),
    .item_priority(item_priority),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .out_name(out_name),
    .out_priority(out_priority),
    .out_position(out_position),
    .entry_count(entry_count),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // Receiver: stalls at random, or holds off for a long counted stretch once when
  // asked, so that the output register fills and the block stalls its input.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run if neither channel has made a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offers one command after a random idle gap and returns at the edge where the
  // transfer happens. Valid is lowered only when a gap follows, so it is never
  // lowered and raised in the same step.
  task automatic send_cmd(input logic [spq_pkg::CMD_W-1:0] cmd,
                          input logic [spq_pkg::NAME_W-1:0] nm,
                          input logic [spq_pkg::PRIO_W-1:0] pr,
                          input logic [spq_pkg::POS_W-1:0] ps);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    item_name <= nm;
    item_priority <= pr;
    position <= ps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // The sender pauses until every result it is owed has been transferred.
  task automatic wait_for_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Command mix: fill segments drive the queue to full and beyond, drain segments
  // empty it and pop past empty, and a few percent of all items use the spare code.
  function automatic logic [spq_pkg::CMD_W-1:0] pick_command(input mix_t mix);
    int r;
    r = $urandom_range(99);
    if (r < 3) return CMD_SPARE;
    case (mix)
      MIX_FILL: begin
        if (r < 50) return spq_pkg::CMD_ENQUEUE;
        if (r < 63) return spq_pkg::CMD_PUSH_HEAD;
        if (r < 76) return spq_pkg::CMD_PUSH_TAIL;
        if (r < 81) return spq_pkg::CMD_POP_HEAD;
        if (r < 85) return spq_pkg::CMD_POP_TAIL;
        if (r < 93) return spq_pkg::CMD_FIND;
        return spq_pkg::CMD_READ;
      end
      MIX_DRAIN: begin
        if (r < 10) return spq_pkg::CMD_ENQUEUE;
        if (r < 14) return spq_pkg::CMD_PUSH_HEAD;
        if (r < 18) return spq_pkg::CMD_PUSH_TAIL;
        if (r < 48) return spq_pkg::CMD_POP_HEAD;
        if (r < 74) return spq_pkg::CMD_POP_TAIL;
        if (r < 87) return spq_pkg::CMD_FIND;
        return spq_pkg::CMD_READ;
      end
      default: begin
        if (r < 28) return spq_pkg::CMD_ENQUEUE;
        if (r < 36) return spq_pkg::CMD_PUSH_HEAD;
        if (r < 44) return spq_pkg::CMD_PUSH_TAIL;
        if (r < 58) return spq_pkg::CMD_POP_HEAD;
        if (r < 70) return spq_pkg::CMD_POP_TAIL;
        if (r < 85) return spq_pkg::CMD_FIND;
        return spq_pkg::CMD_READ;
      end
    endcase
  endfunction

  // Priorities lean on the extremes and on a few small values, so that ties are
  // common and the first-in, first-out order among equals gets exercised.
  function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority;
    case ($urandom_range(9))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      4, 5: return 8'($urandom_range(3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_item(input mix_t mix);
    logic [spq_pkg::CMD_W-1:0]  cmd;
    logic [spq_pkg::NAME_W-1:0] nm;
    logic [spq_pkg::PRIO_W-1:0] pr;
    logic [spq_pkg::POS_W-1:0]  ps;
    cmd = pick_command(mix);
    nm = ($urandom_range(9) < 7) ? name_pool[3'($urandom_range(7))] : $urandom;
    pr = pick_priority();
    ps = 4'($urandom_range(15));
    send_cmd(cmd, nm, pr, ps);
  endtask

  // Random commands in segments of one mix each, the mix changing between segments.
  task automatic run_random(input int count);
    mix_t mix;
    int left;
    int seg;
    left = count;
    while (left > 0) begin
      mix = mix_t'($urandom_range(2));
      seg = 20 + $urandom_range(20);
      while (seg > 0 && left > 0) begin
        random_item(mix);
        seg--;
        left--;
      end
    end
  endtask

  initial begin : stimulus
    int k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= spq_pkg::CMD_ENQUEUE;
    item_name <= '0;
    item_priority <= '0;
    position <= '0;
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (k = 2; k < 8; k++) name_pool[k] = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. On the empty queue: both pops, a find, a read and the spare code.
    send_cmd(spq_pkg::CMD_POP_HEAD, 32'h0000_0000, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_POP_TAIL, 32'hFFFF_FFFF, 8'hFF, 4'd15);
    send_cmd(spq_pkg::CMD_FIND, 32'h0000_0000, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_READ, 32'h0000_0000, 8'h00, 4'd0);
    send_cmd(CMD_SPARE, 32'hFFFF_FFFF, 8'hFF, 4'd15);
    // Enqueue at the priority extremes, then ties that must keep arrival order.
    send_cmd(spq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 8'h7F, 4'd0);
    send_cmd(spq_pkg::CMD_ENQUEUE, 32'h0000_0000, 8'h80, 4'd0);
    send_cmd(spq_pkg::CMD_ENQUEUE, 32'hA5A5_0001, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_ENQUEUE, 32'hA5A5_0002, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_ENQUEUE, 32'h5A5A_0003, 8'h7F, 4'd0);
    // Plain pushes at either end ignore priority.
    send_cmd(spq_pkg::CMD_PUSH_HEAD, 32'h1234_5678, 8'h80, 4'd0);
    send_cmd(spq_pkg::CMD_PUSH_TAIL, 32'h8765_4321, 8'h7F, 4'd0);
    // A find that hits, one that misses, reads in and out of range.
    send_cmd(spq_pkg::CMD_FIND, 32'hA5A5_0002, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_FIND, 32'hDEAD_0000, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_READ, 32'h0000_0000, 8'h00, 4'd15);
    send_cmd(spq_pkg::CMD_READ, 32'h0000_0000, 8'h00, 4'd6);
    send_cmd(spq_pkg::CMD_READ, 32'h0000_0000, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_POP_TAIL, 32'h0000_0000, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_POP_HEAD, 32'h0000_0000, 8'h00, 4'd0);
    send_cmd(spq_pkg::CMD_ENQUEUE, 32'hC0DE_0004, 8'hFF, 4'd0);
    send_cmd(spq_pkg::CMD_FIND, 32'h0000_0000, 8'h00, 4'd0);
    wait_for_results();

    // Slow receiver against a mostly busy sender.
    send_idle_pct = 14;
    recv_stall_pct = 78;
    run_random(250);
    wait_for_results();

    // Slow sender against a mostly ready receiver.
    send_idle_pct = 78;
    recv_stall_pct = 14;
    run_random(250);
    wait_for_results();

    // Neither side idles; in the middle the receiver holds off for a long stretch
    // while the sender keeps offering commands back to back.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(100);
    hold_request = 1'b1;
    for (k = 0; k < 12; k++) random_item(MIX_FILL);
    run_random(138);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
